// ===== src/first_fit_rate_capacity_allocator_defines.svh =====
// Assertion macros shared by the checker.
`ifndef FIRST_FIT_RATE_CAPACITY_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RATE_CAPACITY_ALLOCATOR_DEFINES_SVH

`define FFA_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define FFA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/ffa_pkg.sv =====
package ffa_pkg;
  localparam int RATE_W = 48;
  localparam int TIME_W = 32;
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  localparam logic [2:0] OUT_UNALLOC = 3'd0;
  localparam logic [2:0] OUT_TRANSPORT = 3'd1;
  localparam logic [2:0] OUT_ANCHOR = 3'd2;
  localparam logic [2:0] OUT_SHARED = 3'd3;
  localparam logic [2:0] OUT_NEW = 3'd4;
  localparam logic [2:0] OUT_FULL = 3'd5;

  localparam logic [1:0] KIND_TRANSPORT = 2'd1;
  localparam logic [1:0] KIND_ANCHOR = 2'd2;

  typedef struct packed {
    logic [15:0] task_id;
    logic        place;
    logic [2:0]  outcome;
    logic [15:0] equipment_id;
    logic [7:0]  strategy_id;
    logic [TIME_W-1:0] target_time;
    logic [TIME_W-1:0] achievable_time;
  } job_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [2:0]  outcome;
    logic [3:0]  slot;
  } res_t;
endpackage

// ===== src/ffa_front.sv =====
module ffa_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic [15:0]    in_task_id,
  input  logic           in_has_winner,
  input  logic           in_winner_infeasible,
  input  logic [1:0]     in_kind,
  input  logic           in_has_equipment,
  input  logic [15:0]    in_equipment_id,
  input  logic [7:0]     in_strategy_id,
  input  logic [31:0]    in_target_time,
  input  logic [31:0]    in_achievable_time,
  output logic           q_valid,
  output ffa_pkg::job_t  q_job,
  input  logic           q_take
);
  import ffa_pkg::*;

  // two-entry queue to the back part
  job_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       job;
  logic       push_ok, pop_ok;

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_take && (cnt_r != 2'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rp_r];

  always_comb begin
    job.task_id = in_task_id;
    job.equipment_id = in_equipment_id;
    job.strategy_id = in_strategy_id;
    job.target_time = in_target_time;
    job.achievable_time = in_achievable_time;
    job.place = 1'b0;
    priority if (!in_has_winner || in_winner_infeasible) job.outcome = OUT_UNALLOC;
    else if (in_kind == KIND_TRANSPORT) job.outcome = OUT_TRANSPORT;
    else if (in_kind == KIND_ANCHOR) job.outcome = OUT_ANCHOR;
    else if (!in_has_equipment) job.outcome = OUT_UNALLOC;
    else begin
      job.outcome = OUT_NEW;
      job.place = 1'b1;
    end
  end

  always_comb begin
    wp_nxt = wp_r ^ push_ok;
    rp_nxt = rp_r ^ pop_ok;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_ok) mem_r[wp_r] <= job;
  end
endmodule

// ===== src/ffa_div.sv =====
module ffa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo
);
  import ffa_pkg::*;

  // restoring division of 2^40 by den, one quotient bit a cycle
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [40:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [31:0] d_r, d_nxt;
  logic [32:0] trial;
  logic        done_r, done_nxt;

  assign trial = {rem_r[31:0], num_r[40]};
  assign done = done_r;
  assign quo = q_r;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    d_nxt = d_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt = den;
      num_nxt = 41'd1 << 40;
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = 6'd41;
      busy_nxt = (den != '0);
      if (den == '0) begin
        q_nxt = RATE_MAX;
        done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      num_nxt = {num_r[39:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end
endmodule

// ===== src/ffa_back.sv =====
module ffa_back #(
  parameter int MAX_INSTANCES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    tol,
  input  logic          q_valid,
  input  ffa_pkg::job_t q_job,
  output logic          q_take,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [15:0]   out_result_task,
  output logic [2:0]    out_outcome,
  output logic [3:0]    out_instance_slot
);
  import ffa_pkg::*;

  localparam int SW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int UW = $clog2(MAX_INSTANCES + 1);
  localparam logic [UW-1:0] MAXU = UW'(MAX_INSTANCES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_DIV2 = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [15:0]     eq_mem [MAX_INSTANCES];
  logic [7:0]      st_mem [MAX_INSTANCES];
  logic [RATE_W-1:0] cap_mem [MAX_INSTANCES];
  logic [RATE_W-1:0] com_mem [MAX_INSTANCES];

  logic [2:0]      state_r, state_nxt;
  logic [UW-1:0]   used_r;
  logic [UW-1:0]   idx_r;
  job_t            job_r;
  logic [RATE_W-1:0] need_r, ach_r;
  logic [15:0]     rd_eq;
  logic [7:0]      rd_st;
  logic [RATE_W-1:0] rd_cap, rd_com;
  logic            res_v_r;
  res_t            res_r;
  res_t            wrk_r;
  logic            div_start, div_done;
  logic [31:0]     div_den;
  logic [RATE_W-1:0] div_q;
  logic signed [RATE_W+1:0] spare;
  logic [RATE_W:0] sum;

  ffa_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .den(div_den),
                 .done(div_done), .quo(div_q));

  assign out_empty = !res_v_r;
  assign out_result_task = res_r.task_id;
  assign out_outcome = res_r.outcome;
  assign out_instance_slot = res_r.slot;
  assign q_take = (state_r == ST_IDLE) && q_valid;

  assign spare = $signed({2'b0, rd_cap}) - $signed({2'b0, rd_com})
               + $signed({{RATE_W{1'b0}}, 2'b0} | (RATE_W+2)'(tol));
  assign sum = {1'b0, rd_com} + {1'b0, need_r};

  always_comb begin
    div_start = 1'b0;
    div_den = job_r.target_time;
    unique case (state_r)
      ST_IDLE: div_start = 1'b0;
      ST_DIV1: div_start = 1'b0;
      ST_DIV2: begin
        div_den = job_r.achievable_time;
        div_start = 1'b0;
      end
      default: div_start = 1'b0;
    endcase
    if (state_r == ST_DIV1 && !div_done && idx_r == '0) div_start = 1'b1;
    if (state_r == ST_DIV2 && idx_r == '0) begin
      div_den = job_r.achievable_time;
      div_start = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = q_job.place ? ST_DIV1 : ST_OUT;
      ST_DIV1: if (div_done && idx_r != '0) state_nxt = ST_DIV2;
      ST_DIV2: if (div_done && idx_r != '0) state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = (idx_r < used_r) ? ST_CHK : ST_OUT;
      ST_CHK:  state_nxt = ST_OUT;
      ST_OUT:  if (!res_v_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r <= '0;
      res_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (out_pop && res_v_r) res_v_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          state_r <= state_nxt;
          idx_r <= '0;
          if (q_valid) begin
            job_r <= q_job;
            wrk_r.task_id <= q_job.task_id;
            wrk_r.outcome <= q_job.outcome;
            wrk_r.slot <= '0;
          end
        end
        ST_DIV1, ST_DIV2: begin
          // idx_r doubles as the "started" flag during division
          if (idx_r == '0) idx_r <= UW'(1);
          else if (div_done) begin
            if (state_r == ST_DIV1) need_r <= div_q;
            else ach_r <= div_q;
            idx_r <= '0;
            state_r <= state_nxt;
          end
        end
        ST_SCAN: begin
          if (idx_r < used_r) begin
            rd_eq <= eq_mem[idx_r[SW-1:0]];
            rd_st <= st_mem[idx_r[SW-1:0]];
            rd_cap <= cap_mem[idx_r[SW-1:0]];
            rd_com <= com_mem[idx_r[SW-1:0]];
            state_r <= ST_CHK;
          end else if (used_r >= MAXU) begin
            wrk_r.outcome <= OUT_FULL;
            state_r <= ST_OUT;
          end else begin
            eq_mem[used_r[SW-1:0]] <= job_r.equipment_id;
            st_mem[used_r[SW-1:0]] <= job_r.strategy_id;
            cap_mem[used_r[SW-1:0]] <= ach_r;
            com_mem[used_r[SW-1:0]] <= need_r;
            used_r <= used_r + UW'(1);
            wrk_r.outcome <= OUT_NEW;
            wrk_r.slot <= 4'(used_r);
            state_r <= ST_OUT;
          end
        end
        ST_CHK: begin
          if (rd_eq == job_r.equipment_id && rd_st == job_r.strategy_id &&
              $signed({2'b0, need_r}) <= spare) begin
            com_mem[idx_r[SW-1:0]] <= sum[RATE_W] ? RATE_MAX : sum[RATE_W-1:0];
            wrk_r.outcome <= OUT_SHARED;
            wrk_r.slot <= 4'(idx_r);
            state_r <= ST_OUT;
          end else begin
            idx_r <= idx_r + UW'(1);
            state_r <= ST_SCAN;
          end
        end
        ST_OUT: begin
          if (!res_v_r) begin
            res_r <= wrk_r;
            res_v_r <= 1'b1;
            state_r <= state_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== src/first_fit_rate_capacity_allocator.sv =====
// A word that is not placed goes from the queue straight to the output; a placed word
// passes both divisions, then a first-fit scan of the used slots in order.
// The back part handles one word at a time; the two divisions share one bit-serial divider.
// Two words queue between front and back; one finished word waits at the output.
// Reset (synchronous, rst_n low): queue, slot count and result emptied, tolerance 1.
module first_fit_rate_capacity_allocator #(
  parameter int MAX_INSTANCES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_task_id,
  input  logic        in_has_winner,
  input  logic        in_winner_infeasible,
  input  logic [1:0]  in_kind,
  input  logic        in_has_equipment,
  input  logic [15:0] in_equipment_id,
  input  logic [7:0]  in_strategy_id,
  input  logic [31:0] in_target_time,
  input  logic [31:0] in_achievable_time,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_result_task,
  output logic [2:0]  out_outcome,
  output logic [3:0]  out_instance_slot,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffa_pkg::*;

  logic [7:0] tol_r;
  logic       q_valid, q_take;
  job_t       q_job;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 8'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      tol_r <= cfg_pwdata[7:0];
  end

  ffa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_task_id(in_task_id), .in_has_winner(in_has_winner),
    .in_winner_infeasible(in_winner_infeasible), .in_kind(in_kind),
    .in_has_equipment(in_has_equipment), .in_equipment_id(in_equipment_id),
    .in_strategy_id(in_strategy_id), .in_target_time(in_target_time),
    .in_achievable_time(in_achievable_time),
    .q_valid(q_valid), .q_job(q_job), .q_take(q_take)
  );

  ffa_back #(.MAX_INSTANCES(MAX_INSTANCES)) u_back (
    .clk(clk), .rst_n(rst_n), .tol(tol_r), .q_valid(q_valid), .q_job(q_job),
    .q_take(q_take), .out_empty(out_empty), .out_pop(out_pop),
    .out_result_task(out_result_task), .out_outcome(out_outcome),
    .out_instance_slot(out_instance_slot)
  );
endmodule

// ===== src/ffa_checker.sv =====
`include "first_fit_rate_capacity_allocator_defines.svh"
module ffa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_outcome,
  input logic [3:0] out_instance_slot,
  input logic       cfg_pready
);
  import ffa_pkg::*;

  logic no_slot;

  assign no_slot = !out_empty && out_outcome != OUT_SHARED && out_outcome != OUT_NEW;

  `FFA_ASSERT_IMPL(a_outcome_range, clk, rst_n, !out_empty, out_outcome <= OUT_FULL)
  `FFA_ASSERT_IMPL(a_slot_zero, clk, rst_n, no_slot, out_instance_slot == 4'd0)
  `FFA_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_outcome))
  `FFA_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, cfg_pready)
endmodule

bind first_fit_rate_capacity_allocator ffa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_outcome(out_outcome), .out_instance_slot(out_instance_slot),
  .cfg_pready(cfg_pready)
);
